/* design/ssl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, token kinds and keyword tables for the SQL subset lexer.
// ----------------------------------------------------------------------------
package ssl_pkg;

   // Width of the byte position and token start counters.
   localparam int POS_W = 16;

   // Result queue depth and pointer widths.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Most records one input byte can produce.
   localparam int MAX_RECS = 3;

   localparam logic [15:0] TOKEN_LIMIT_RESET = 16'd10240;

   // Token kinds; keywords take codes 0..7 in table order.
   localparam logic [4:0] KIND_STAR    = 5'd8;
   localparam logic [4:0] KIND_EQ      = 5'd9;
   localparam logic [4:0] KIND_COMMA   = 5'd10;
   localparam logic [4:0] KIND_LPAREN  = 5'd11;
   localparam logic [4:0] KIND_RPAREN  = 5'd12;
   localparam logic [4:0] KIND_TEXT    = 5'd13;
   localparam logic [4:0] KIND_IDENT   = 5'd14;
   localparam logic [4:0] KIND_INTEGER = 5'd15;
   localparam logic [4:0] KIND_SEMI    = 5'd16;
   localparam logic [4:0] KIND_END     = 5'd17;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_WORD   = 3'd1,
      MODE_IDENT  = 3'd2,
      MODE_NUMBER = 3'd3,
      MODE_TEXT   = 3'd4,
      MODE_DONE   = 3'd5
   } ssl_mode_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
   } ssl_req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] start_offset;
      logic [15:0] value_length;
      logic        last_of_item;
   } ssl_rsp_type;

   typedef struct packed {
      ssl_mode_type     mode;
      logic [7:0]       cand;
      logic [2:0]       match_count;
      logic [POS_W-1:0] token_start;
      logic [POS_W-1:0] byte_pos;
      logic [15:0]      emitted;
   } ssl_state_type;

   // Keyword text, left aligned, zero padded.
   function automatic logic [47:0] kw_text(input logic [2:0] k);
      logic [47:0] t;
      case (k)
         3'd0:    t = "SELECT";
         3'd1:    t = "CREATE";
         3'd2:    t = {"TABLE", 8'h00};
         3'd3:    t = {"FROM", 16'h0000};
         3'd4:    t = {"WHERE", 8'h00};
         3'd5:    t = "INSERT";
         3'd6:    t = {"INTO", 16'h0000};
         default: t = "VALUES";
      endcase
      return t;
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] k);
      logic [2:0] n;
      case (k)
         3'd2, 3'd4: n = 3'd5;
         3'd3, 3'd6: n = 3'd4;
         default:    n = 3'd6;
      endcase
      return n;
   endfunction

endpackage

/* design/ssl_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_step
// Per-byte lexer update: next state and up to three token records.
// ----------------------------------------------------------------------------
module ssl_step (
   input  ssl_pkg::ssl_state_type st,
   input  logic [15:0]            token_limit,
   input  ssl_pkg::ssl_req_type   req,
   output ssl_pkg::ssl_state_type nxt,
   output ssl_pkg::ssl_rsp_type   recs [ssl_pkg::MAX_RECS],
   output logic [1:0]             rec_count
);
   import ssl_pkg::*;

   logic [7:0]       c;
   logic             c_upper, c_lower, c_digit, c_word, c_quote, c_punct;
   logic [4:0]       punct_kind;
   logic [POS_W-1:0] pos, pos_inc, len;
   logic [7:0]       kw_next, kw_first;
   logic             kw_hit;
   logic [2:0]       kw_idx;
   logic [2:0]       mc_inc;
   logic [47:0]      kw_shift [8];

   // flushed token
   logic             a_do;
   logic [4:0]       a_kind;
   logic [POS_W-1:0] a_start, a_len, a_resume;
   logic             fresh_do, end_tail, stop;
   logic [1:0]       n;
   logic [15:0]      cnt;

   assign c       = req.char_code;
   assign c_upper = (c >= "A") && (c <= "Z");
   assign c_lower = (c >= "a") && (c <= "z");
   assign c_digit = (c >= "0") && (c <= "9");
   assign c_word  = c_upper || c_lower || c_digit || (c == "_");
   assign c_quote = (c == "\"");
   assign pos     = st.byte_pos;
   assign pos_inc = pos + POS_W'(1);
   assign len     = pos - st.token_start;
   assign mc_inc  = st.match_count + 3'd1;

   always_comb begin
      c_punct    = 1'b1;
      punct_kind = KIND_STAR;
      case (c)
         "*":     punct_kind = KIND_STAR;
         "=":     punct_kind = KIND_EQ;
         ",":     punct_kind = KIND_COMMA;
         "(":     punct_kind = KIND_LPAREN;
         ")":     punct_kind = KIND_RPAREN;
         ";":     punct_kind = KIND_SEMI;
         default: c_punct = 1'b0;
      endcase
   end

   // Keyword candidate tracking.
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = 3'd0;
      for (int k = 0; k < 8; k++) begin
         kw_shift[k] = kw_text(3'(k)) << {st.match_count, 3'b000};
         kw_next[k]  = st.cand[k] && (st.match_count < kw_len(3'(k)))
                       && (kw_shift[k][47:40] == c);
         kw_first[k] = (kw_text(3'(k)) >> 40) == 48'(c);
      end
      for (int k = 7; k >= 0; k--) begin
         if (kw_next[k] && (kw_len(3'(k)) == mc_inc)) begin
            kw_hit = 1'b1;
            kw_idx = 3'(k);
         end
      end
   end

   always_comb begin
      nxt      = st;
      a_do     = 1'b0;
      a_kind   = KIND_IDENT;
      a_start  = st.token_start;
      a_len    = len;
      a_resume = pos;
      fresh_do = 1'b0;
      end_tail = 1'b0;
      stop     = 1'b0;
      n        = 2'd0;
      cnt      = st.emitted;
      for (int i = 0; i < MAX_RECS; i++) begin
         recs[i] = '0;
      end

      if (req.is_end) begin
         end_tail = (st.mode != MODE_DONE);
         if ((st.mode == MODE_WORD) || (st.mode == MODE_IDENT)) begin
            a_do = 1'b1;
         end else if (st.mode == MODE_NUMBER) begin
            a_do   = 1'b1;
            a_kind = KIND_INTEGER;
         end
      end else begin
         unique case (st.mode)
            MODE_WORD: begin
               if (kw_next != 8'd0) begin
                  nxt.match_count = mc_inc;
                  nxt.cand        = kw_next;
                  if (kw_hit) begin
                     nxt.mode        = MODE_IDLE;
                     nxt.cand        = '0;
                     nxt.match_count = '0;
                     a_do            = 1'b1;
                     a_kind          = {2'b00, kw_idx};
                     a_len           = POS_W'(kw_len(kw_idx));
                     a_resume        = pos_inc;
                  end
               end else if (c_word) begin
                  nxt.mode        = MODE_IDENT;
                  nxt.cand        = '0;
                  nxt.match_count = '0;
               end else begin
                  a_do     = 1'b1;
                  fresh_do = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (!c_word) begin
                  a_do     = 1'b1;
                  fresh_do = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (!c_digit) begin
                  a_do     = 1'b1;
                  a_kind   = KIND_INTEGER;
                  fresh_do = 1'b1;
               end
            end
            MODE_TEXT: begin
               if (c_quote) begin
                  nxt.mode = MODE_IDLE;
                  a_do     = 1'b1;
                  a_kind   = KIND_TEXT;
                  a_resume = pos_inc;
               end
            end
            MODE_IDLE: begin
               fresh_do = 1'b1;
            end
            MODE_DONE: begin
            end
            default: begin
            end
         endcase
         if (st.mode != MODE_DONE) begin
            nxt.byte_pos = pos_inc;
         end
      end

      // token closed by this byte
      if (a_do) begin
         recs[n].token_kind   = a_kind;
         recs[n].start_offset = 16'(a_start);
         recs[n].value_length = 16'(a_len);
         n   = n + 2'd1;
         cnt = cnt + 16'd1;
         if (cnt >= token_limit) begin
            recs[n].token_kind   = KIND_END;
            recs[n].start_offset = 16'(a_resume);
            n    = n + 2'd1;
            stop = 1'b1;
         end
      end

      // token started (or single-byte token) at this byte
      if (fresh_do && !stop) begin
         nxt.mode        = MODE_IDLE;
         nxt.cand        = '0;
         nxt.match_count = '0;
         if (c_upper || c_lower) begin
            nxt.token_start = pos;
            if (kw_first != 8'd0) begin
               nxt.mode        = MODE_WORD;
               nxt.cand        = kw_first;
               nxt.match_count = 3'd1;
            end else begin
               nxt.mode = MODE_IDENT;
            end
         end else if (c_digit) begin
            nxt.token_start = pos;
            nxt.mode        = MODE_NUMBER;
         end else if (c_quote) begin
            nxt.token_start = pos_inc;
            nxt.mode        = MODE_TEXT;
         end else if (c_punct) begin
            recs[n].token_kind   = punct_kind;
            recs[n].start_offset = 16'(pos);
            recs[n].value_length = 16'd1;
            n   = n + 2'd1;
            cnt = cnt + 16'd1;
            if (cnt >= token_limit) begin
               recs[n].token_kind   = KIND_END;
               recs[n].start_offset = 16'(pos_inc);
               n    = n + 2'd1;
               stop = 1'b1;
            end
         end
      end

      if (stop) begin
         nxt.mode        = MODE_DONE;
         nxt.cand        = '0;
         nxt.match_count = '0;
      end
      nxt.emitted = cnt;

      if (req.is_end) begin
         if (end_tail && !stop) begin
            recs[n].token_kind   = KIND_END;
            recs[n].start_offset = 16'(pos);
            n = n + 2'd1;
         end
         nxt.mode        = MODE_IDLE;
         nxt.cand        = '0;
         nxt.match_count = '0;
         nxt.token_start = '0;
         nxt.byte_pos    = '0;
         nxt.emitted     = '0;
      end

      for (int i = 0; i < MAX_RECS; i++) begin
         recs[i].last_of_item = (2'(i) == n - 2'd1);
      end
   end

   assign rec_count = n;

endmodule

/* design/ssl_rsp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_rsp_fifo
// Result queue: takes up to three records a cycle, sends one per beat.
// ----------------------------------------------------------------------------
module ssl_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  ssl_pkg::ssl_rsp_type push_recs [ssl_pkg::MAX_RECS],
   output logic                 almost_full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssl_pkg::ssl_rsp_type rsp_data
);
   import ssl_pkg::*;

   ssl_rsp_type            mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign count_in    = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(pop);
   // room must remain for a full burst from one byte
   assign almost_full = (count_ff > RSP_CNT_W'(RSP_DEPTH - MAX_RECS));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(push_count);
         rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RECS; i++) begin
         if (2'(i) < push_count) begin
            mem_ff[wr_ptr_ff + RSP_PTR_W'(i)] <= push_recs[i];
         end
      end
   end

endmodule

/* design/sql_subset_lexer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_subset_lexer_top
// Streaming tokenizer for a small SQL subset, one byte per beat.
// ----------------------------------------------------------------------------
// Feed one statement byte per req beat (is_end set on a closing beat that
// carries no byte). The lexer takes one beat every cycle while req_stall is
// low: the token state update for a byte is a single combinational step
// between the state registers, so throughput is one byte per clock. Each
// byte produces zero to three records (closed token, single-byte token, end
// record), and records leave on the rsp channel at one per beat through an
// 8-entry queue; the last record of a byte carries last_of_item. req_stall
// rises when fewer than three queue slots are free, so a burst of multi-record
// bytes, or a stalled rsp side, paces the input. Records of an accepted byte
// are registered in the queue. Keywords match upper case only and as plain
// prefixes ("SELECTX" gives SELECT then identifier X). Once token_limit
// tokens are emitted an end record closes the statement and bytes up to the
// next end beat are dropped. token_limit is written through csr, always ready,
// and should only be changed while the block is idle; it resets to 10240.
// ----------------------------------------------------------------------------
module sql_subset_lexer_top (
   input  logic                 clock,
   input  logic                 reset,
   // byte input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ssl_pkg::ssl_req_type req_data,
   // token records
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssl_pkg::ssl_rsp_type rsp_data,
   // token_limit register
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);
   import ssl_pkg::*;

   ssl_state_type state_ff, state_in;
   logic [15:0]   limit_ff;
   ssl_rsp_type   recs [MAX_RECS];
   logic [1:0]    rec_count;
   logic [1:0]    push_count;
   logic          accept;
   logic          almost_full;

   assign csr_ready  = 1'b1;
   assign req_stall  = almost_full;
   assign accept     = req_valid && !req_stall;
   assign push_count = accept ? rec_count : 2'd0;

   // Byte-level lexer step.
   ssl_step u_step (
      .st          (state_ff),
      .token_limit (limit_ff),
      .req         (req_data),
      .nxt         (state_in),
      .recs        (recs),
      .rec_count   (rec_count)
   );

   // Lexer state only advances on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_IDLE, default: '0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TOKEN_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // Records wait here until the rsp side takes them.
   ssl_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_recs   (recs),
      .almost_full (almost_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SQL subset lexer.
// ----------------------------------------------------------------------------
// A short directed byte stream runs first. Random SQL-like statements follow,
// under several token_limit settings, most with random gaps on both channels.
// A behavioral lexer predicts the token records of every accepted byte. Each
// record beat is checked in order against those predictions.
// ----------------------------------------------------------------------------
module tb_top;
   import ssl_pkg::*;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE       = 8;     // idle cycles after the last record
   localparam int HANG_LIMIT   = 2000;  // cycles without any beat

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ssl_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ssl_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   sql_subset_lexer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   ssl_req_type byte_q[$];     // bytes waiting to be driven
   ssl_rsp_type token_q[$];    // predicted records, oldest first
   ssl_rsp_type byte_recs[$];  // records of the byte being lexed

   string kw_names [8] = '{"SELECT", "CREATE", "TABLE", "FROM",
                           "WHERE", "INSERT", "INTO", "VALUES"};
   string punct_chars = "*=,();";

   // lexer state as seen by the bench
   logic [15:0]      tok_limit   = TOKEN_LIMIT_RESET;
   ssl_mode_type     lex_mode_r  = MODE_IDLE;
   logic [7:0]       cand_r      = '0;
   int               match_r     = 0;
   logic [POS_W-1:0] tok_start_r = '0;
   logic [POS_W-1:0] pos_r       = '0;
   logic [15:0]      emitted_r   = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors        = 0;
   int idle_cycles   = 0;

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic void add_rec(logic [4:0] kind, logic [POS_W-1:0] start,
                                   logic [POS_W-1:0] len);
      ssl_rsp_type r;
      r.token_kind   = kind;
      r.start_offset = 16'(start);
      r.value_length = 16'(len);
      r.last_of_item = 1'b0;
      byte_recs.push_back(r);
   endfunction

   // Returns 1 when this token hits the limit and closes the statement.
   function automatic bit emit_token(logic [4:0] kind, logic [POS_W-1:0] start,
                                     logic [POS_W-1:0] len,
                                     logic [POS_W-1:0] resume);
      add_rec(kind, start, len);
      emitted_r = emitted_r + 16'd1;
      if (emitted_r >= tok_limit) begin
         add_rec(KIND_END, resume, '0);
         lex_mode_r = MODE_DONE;
         cand_r     = '0;
         match_r    = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void clear_statement();
      lex_mode_r  = MODE_IDLE;
      cand_r      = '0;
      match_r     = 0;
      tok_start_r = '0;
      pos_r       = '0;
      emitted_r   = '0;
   endfunction

   // Byte seen between tokens: open a token, emit a one-char token, or skip.
   function automatic void start_token(logic [7:0] c);
      logic [7:0] first;
      lex_mode_r = MODE_IDLE;
      cand_r     = '0;
      match_r    = 0;
      if (is_alpha(c)) begin
         first = '0;
         for (int k = 0; k < 8; k++)
            if (kw_names[k][0] == c) first[k] = 1'b1;
         tok_start_r = pos_r;
         if (first != '0) begin
            lex_mode_r = MODE_WORD;
            cand_r     = first;
            match_r    = 1;
         end else begin
            lex_mode_r = MODE_IDENT;
         end
      end else if (is_digit(c)) begin
         tok_start_r = pos_r;
         lex_mode_r  = MODE_NUMBER;
      end else if (c == "\"") begin
         tok_start_r = pos_r + 1'b1;
         lex_mode_r  = MODE_TEXT;
      end else begin
         case (c)
            "*":     void'(emit_token(KIND_STAR, pos_r, POS_W'(1), pos_r + 1'b1));
            "=":     void'(emit_token(KIND_EQ, pos_r, POS_W'(1), pos_r + 1'b1));
            ",":     void'(emit_token(KIND_COMMA, pos_r, POS_W'(1), pos_r + 1'b1));
            "(":     void'(emit_token(KIND_LPAREN, pos_r, POS_W'(1), pos_r + 1'b1));
            ")":     void'(emit_token(KIND_RPAREN, pos_r, POS_W'(1), pos_r + 1'b1));
            ";":     void'(emit_token(KIND_SEMI, pos_r, POS_W'(1), pos_r + 1'b1));
            default: ;
         endcase
      end
   endfunction

   // Predicts the records of one accepted beat and queues them.
   function automatic void lex_byte(ssl_req_type b);
      logic [7:0]       c;
      logic [7:0]       nxt;
      logic [POS_W-1:0] p;
      logic [POS_W-1:0] len;
      bit               stopped;
      bit               hit;
      ssl_rsp_type      r;
      c   = b.char_code;
      p   = pos_r;
      len = p - tok_start_r;
      byte_recs.delete();
      if (b.is_end) begin
         if (lex_mode_r != MODE_DONE) begin
            stopped = 1'b0;
            if (lex_mode_r == MODE_WORD || lex_mode_r == MODE_IDENT)
               stopped = emit_token(KIND_IDENT, tok_start_r, len, p);
            else if (lex_mode_r == MODE_NUMBER)
               stopped = emit_token(KIND_INTEGER, tok_start_r, len, p);
            if (!stopped) add_rec(KIND_END, p, '0);
         end
         clear_statement();
      end else if (lex_mode_r != MODE_DONE) begin
         case (lex_mode_r)
            MODE_WORD: begin
               nxt = '0;
               for (int k = 0; k < 8; k++)
                  if (cand_r[k] && match_r < kw_names[k].len() &&
                      kw_names[k][match_r] == c)
                     nxt[k] = 1'b1;
               if (nxt != '0) begin
                  match_r = match_r + 1;
                  cand_r  = nxt;
                  hit     = 1'b0;
                  for (int k = 0; k < 8; k++) begin
                     if (!hit && nxt[k] && kw_names[k].len() == match_r) begin
                        hit        = 1'b1;
                        lex_mode_r = MODE_IDLE;
                        cand_r     = '0;
                        match_r    = 0;
                        void'(emit_token(5'(k), tok_start_r,
                                         POS_W'(kw_names[k].len()), p + 1'b1));
                     end
                  end
               end else if (is_word(c)) begin
                  // keyword prefix broken by a word char: plain identifier
                  lex_mode_r = MODE_IDENT;
                  cand_r     = '0;
                  match_r    = 0;
               end else if (!emit_token(KIND_IDENT, tok_start_r, len, p)) begin
                  start_token(c);
               end
            end
            MODE_IDENT: begin
               if (!is_word(c))
                  if (!emit_token(KIND_IDENT, tok_start_r, len, p)) start_token(c);
            end
            MODE_NUMBER: begin
               if (!is_digit(c))
                  if (!emit_token(KIND_INTEGER, tok_start_r, len, p)) start_token(c);
            end
            MODE_TEXT: begin
               if (c == "\"") begin
                  lex_mode_r = MODE_IDLE;
                  void'(emit_token(KIND_TEXT, tok_start_r, len, p + 1'b1));
               end
            end
            default: start_token(c);
         endcase
         pos_r = p + 1'b1;
      end
      if (byte_recs.size() != 0) begin
         r = byte_recs.pop_back();
         r.last_of_item = 1'b1;
         byte_recs.push_back(r);
      end
      foreach (byte_recs[i]) token_q.push_back(byte_recs[i]);
   endfunction

   function automatic void report_field(string name, int want, int got);
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
   endfunction

   function automatic void check_record(ssl_rsp_type got);
      ssl_rsp_type want;
      if (token_q.size() == 0) begin
         $display("%0t ns: unexpected record, expected none, got kind %0d start %0d len %0d",
                  $time, got.token_kind, got.start_offset, got.value_length);
         errors++;
         return;
      end
      want = token_q.pop_front();
      if (got.token_kind !== want.token_kind)
         report_field("token_kind", int'(want.token_kind), int'(got.token_kind));
      if (got.start_offset !== want.start_offset)
         report_field("start_offset", int'(want.start_offset), int'(got.start_offset));
      if (got.value_length !== want.value_length)
         report_field("value_length", int'(want.value_length), int'(got.value_length));
      if (got.last_of_item !== want.last_of_item)
         report_field("last_of_item", int'(want.last_of_item), int'(got.last_of_item));
   endfunction

   // --- stimulus builders ---------------------------------------------------

   function automatic void push_byte(logic [7:0] c);
      ssl_req_type b;
      b.char_code = c;
      b.is_end    = 1'b0;
      byte_q.push_back(b);
   endfunction

   function automatic void push_end(logic [7:0] c);
      ssl_req_type b;
      b.char_code = c;
      b.is_end    = 1'b1;
      byte_q.push_back(b);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [7:0] letter();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range("A", "Z"));
      return 8'($urandom_range("a", "z"));
   endfunction

   function automatic logic [7:0] word_char();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return letter();
      if (pick < 9) return 8'($urandom_range("0", "9"));
      return "_";
   endfunction

   function automatic void push_quoted(bit closed);
      logic [7:0] c;
      int         n;
      push_byte("\"");
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         c = 8'($urandom_range(32, 126));
         if (c == "\"") c = "_";
         push_byte(c);
      end
      if (closed) push_byte("\"");
   endfunction

   // One token-sized piece of a statement, usually followed by a blank.
   function automatic void push_fragment();
      int pick;
      int n;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // keyword, sometimes cut short, sometimes run into a word char
         k = $urandom_range(0, 7);
         n = kw_names[k].len();
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
         for (int i = 0; i < n; i++) push_byte(kw_names[k][i]);
         if ($urandom_range(0, 2) == 0) push_byte(word_char());
      end else if (pick < 45) begin
         push_byte(letter());
         n = $urandom_range(0, 5);
         for (int i = 0; i < n; i++) push_byte(word_char());
      end else if (pick < 55) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) push_byte(8'($urandom_range("0", "9")));
      end else if (pick < 70) begin
         push_byte(punct_chars[$urandom_range(0, 5)]);
      end else if (pick < 78) begin
         push_quoted(1'b1);
      end else if (pick < 85) begin
         push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) < 7) push_byte(" ");
   endfunction

   function automatic void push_statement();
      int frags;
      frags = $urandom_range(3, 10);
      for (int i = 0; i < frags; i++) push_fragment();
      // text left open at the end marker is dropped
      if ($urandom_range(0, 7) == 0) push_quoted(1'b0);
      push_end(8'($urandom_range(0, 255)));
   endfunction

   // --- driver, monitor, watchdog -------------------------------------------

   // Prediction happens at the edge where the beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) lex_byte(req_data);
         if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= byte_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) check_record(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --- sequencing ----------------------------------------------------------

   // All bytes taken, all records back, then a quiet settle wait.
   task automatic drain();
      while (byte_q.size() != 0 || req_valid) @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_limit(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tok_limit = value;
   endtask

   task automatic random_phase(input logic [15:0] limit_value, input int n_bytes);
      set_limit(limit_value);
      while (byte_q.size() < n_bytes) push_statement();
      drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 51;

      // directed: keyword run into ident, text, all punctuation, number,
      // byte extremes, keyword prefix flushed as ident by the end marker
      push_text("SELECTX\"ab\"*=,();12");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_text("FR");
      push_end(8'hFF);
      drain();

      random_phase(16'hFFFF, 20);
      random_phase(16'd1, 15);

      send_idle_pct = 51;
      recv_idle_pct = 15;
      random_phase(16'd3, 18);
      random_phase(16'd2, 15);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(16'd7, 18);
      random_phase(TOKEN_LIMIT_RESET, 20);

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sql_subset_lexer_top.f */
design/ssl_pkg.sv
design/ssl_step.sv
design/ssl_rsp_fifo.sv
design/sql_subset_lexer_top.sv
verif/tb_top.sv
